@@ sv/qmam_pkg.sv @@
// ----------------------------------------------------------------------------
// Quad motor arming mixer package
// Shared widths, reset values, register and state codes, and word types.
// ----------------------------------------------------------------------------
package qmam_pkg;

  localparam int unsigned THR_W  = 11;
  localparam int unsigned DRV_W  = 11;
  localparam int unsigned MOT_W  = 10;
  localparam int unsigned LVL_W  = 13;
  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;

  localparam logic [THR_W-1:0] THROTTLE_OFFSET_RST  = 11'd1000;
  localparam logic [THR_W-1:0] START_THRESHOLD_RST  = 11'd1100;
  localparam logic [THR_W-1:0] HOLD_THRESHOLD_RST   = 11'd1200;
  localparam logic [THR_W-1:0] CUTOFF_THRESHOLD_RST = 11'd1020;
  localparam logic [MOT_W-1:0] IDLE_LEVEL_RST       = 10'd200;
  localparam logic [MOT_W-1:0] BASE_LIMIT_RST       = 10'd900;
  localparam logic [MOT_W-1:0] OUTPUT_MAX_RST       = 10'd1000;

  typedef enum logic [2:0] {
    REG_THROTTLE_OFFSET  = 3'd0,
    REG_START_THRESHOLD  = 3'd1,
    REG_HOLD_THRESHOLD   = 3'd2,
    REG_CUTOFF_THRESHOLD = 3'd3,
    REG_IDLE_LEVEL       = 3'd4,
    REG_BASE_LIMIT       = 3'd5,
    REG_OUTPUT_MAX       = 3'd6
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_WAIT_ARM = 3'd0,
    ST_WAIT_THR = 3'd1,
    ST_RUN      = 3'd2,
    ST_EXIT     = 3'd3,
    ST_PARKED   = 3'd4
  } arm_state_t;

  typedef enum logic [1:0] {
    LV_HOLD,
    LV_ZERO,
    LV_IDLE,
    LV_MIX
  } lvl_sel_t;

  typedef logic signed [LVL_W-1:0] level_t;

  typedef struct packed {
    logic [THR_W-1:0] throttle_offset;
    logic [THR_W-1:0] start_threshold;
    logic [THR_W-1:0] hold_threshold;
    logic [THR_W-1:0] cutoff_threshold;
    logic [MOT_W-1:0] idle_level;
    logic [MOT_W-1:0] base_limit;
    logic [MOT_W-1:0] output_max;
  } cfg_t;

  typedef struct packed {
    logic                    armed;
    logic                    unfolded;
    logic                    auto_mode;
    logic                    hold_request;
    logic                    procedure_ready;
    logic [THR_W-1:0]        throttle;
    logic signed [DRV_W-1:0] height_drive;
    logic signed [DRV_W-1:0] roll_drive;
    logic signed [DRV_W-1:0] pitch_drive;
    logic signed [DRV_W-1:0] yaw_drive;
  } in_word_t;

  typedef struct packed {
    logic [MOT_W-1:0] motor_one;
    logic [MOT_W-1:0] motor_two;
    logic [MOT_W-1:0] motor_three;
    logic [MOT_W-1:0] motor_four;
    logic             clear_hold_flags;
  } out_word_t;

endpackage

@@ sv/qmam_if.sv @@
// ----------------------------------------------------------------------------
// Quad motor arming mixer channels
// Valid/ready channels for the control tick word and the motor word.
// ----------------------------------------------------------------------------
interface qmam_in_if;
  import qmam_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    armed;
  logic                    unfolded;
  logic                    auto_mode;
  logic                    hold_request;
  logic                    procedure_ready;
  logic [THR_W-1:0]        throttle;
  logic signed [DRV_W-1:0] height_drive;
  logic signed [DRV_W-1:0] roll_drive;
  logic signed [DRV_W-1:0] pitch_drive;
  logic signed [DRV_W-1:0] yaw_drive;

  modport source (
    output valid, armed, unfolded, auto_mode, hold_request, procedure_ready,
           throttle, height_drive, roll_drive, pitch_drive, yaw_drive,
    input  ready
  );

  modport sink (
    input  valid, armed, unfolded, auto_mode, hold_request, procedure_ready,
           throttle, height_drive, roll_drive, pitch_drive, yaw_drive,
    output ready
  );
endinterface

interface qmam_out_if;
  import qmam_pkg::*;

  logic             valid;
  logic             ready;
  logic [MOT_W-1:0] motor_one;
  logic [MOT_W-1:0] motor_two;
  logic [MOT_W-1:0] motor_three;
  logic [MOT_W-1:0] motor_four;
  logic             clear_hold_flags;

  modport source (
    output valid, motor_one, motor_two, motor_three, motor_four, clear_hold_flags,
    input  ready
  );

  modport sink (
    input  valid, motor_one, motor_two, motor_three, motor_four, clear_hold_flags,
    output ready
  );
endinterface

@@ sv/qmam_cfg.sv @@
// ----------------------------------------------------------------------------
// Quad motor arming mixer configuration registers
// APB-style register file holding thresholds and limits.
// ----------------------------------------------------------------------------
module qmam_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [qmam_pkg::ADDR_W-1:0]  paddr,
  input  logic [qmam_pkg::DATA_W-1:0]  pwdata,
  output logic [qmam_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  output qmam_pkg::cfg_t               cfg
);
  import qmam_pkg::*;

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_THROTTLE_OFFSET:  cfg_nxt.throttle_offset  = pwdata[THR_W-1:0];
        REG_START_THRESHOLD:  cfg_nxt.start_threshold  = pwdata[THR_W-1:0];
        REG_HOLD_THRESHOLD:   cfg_nxt.hold_threshold   = pwdata[THR_W-1:0];
        REG_CUTOFF_THRESHOLD: cfg_nxt.cutoff_threshold = pwdata[THR_W-1:0];
        REG_IDLE_LEVEL:       cfg_nxt.idle_level       = pwdata[MOT_W-1:0];
        REG_BASE_LIMIT:       cfg_nxt.base_limit       = pwdata[MOT_W-1:0];
        REG_OUTPUT_MAX:       cfg_nxt.output_max       = pwdata[MOT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_THROTTLE_OFFSET:  prdata = DATA_W'(cfg_r.throttle_offset);
      REG_START_THRESHOLD:  prdata = DATA_W'(cfg_r.start_threshold);
      REG_HOLD_THRESHOLD:   prdata = DATA_W'(cfg_r.hold_threshold);
      REG_CUTOFF_THRESHOLD: prdata = DATA_W'(cfg_r.cutoff_threshold);
      REG_IDLE_LEVEL:       prdata = DATA_W'(cfg_r.idle_level);
      REG_BASE_LIMIT:       prdata = DATA_W'(cfg_r.base_limit);
      REG_OUTPUT_MAX:       prdata = DATA_W'(cfg_r.output_max);
      default:              prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.throttle_offset  <= THROTTLE_OFFSET_RST;
      cfg_r.start_threshold  <= START_THRESHOLD_RST;
      cfg_r.hold_threshold   <= HOLD_THRESHOLD_RST;
      cfg_r.cutoff_threshold <= CUTOFF_THRESHOLD_RST;
      cfg_r.idle_level       <= IDLE_LEVEL_RST;
      cfg_r.base_limit       <= BASE_LIMIT_RST;
      cfg_r.output_max       <= OUTPUT_MAX_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

@@ sv/qmam_mix.sv @@
// ----------------------------------------------------------------------------
// Quad motor arming mixer X-frame mix
// Common thrust from throttle and height drive, clamped, then attitude mix.
// ----------------------------------------------------------------------------
module qmam_mix (
  input  qmam_pkg::in_word_t word,
  input  qmam_pkg::cfg_t     cfg,
  output qmam_pkg::level_t   mix [4]
);
  import qmam_pkg::*;

  level_t thr_s;
  level_t off_s;
  level_t hgt_s;
  level_t rx_s;
  level_t py_s;
  level_t yz_s;
  level_t lim_s;
  level_t raw;
  level_t base;

  assign thr_s = $signed({2'b00, word.throttle});
  assign off_s = $signed({2'b00, cfg.throttle_offset});
  assign lim_s = $signed({3'b000, cfg.base_limit});
  assign hgt_s = {{(LVL_W-DRV_W){word.height_drive[DRV_W-1]}}, word.height_drive};
  assign rx_s  = {{(LVL_W-DRV_W){word.roll_drive[DRV_W-1]}}, word.roll_drive};
  assign py_s  = {{(LVL_W-DRV_W){word.pitch_drive[DRV_W-1]}}, word.pitch_drive};
  assign yz_s  = {{(LVL_W-DRV_W){word.yaw_drive[DRV_W-1]}}, word.yaw_drive};

  assign raw = thr_s - off_s + hgt_s;

  always_comb begin
    if (raw < 0) begin
      base = '0;
    end else if (raw > lim_s) begin
      base = lim_s;
    end else begin
      base = raw;
    end
  end

  assign mix[0] = base + rx_s - py_s - yz_s;
  assign mix[1] = base + rx_s + py_s + yz_s;
  assign mix[2] = base - rx_s + py_s - yz_s;
  assign mix[3] = base - rx_s - py_s + yz_s;

endmodule

@@ sv/qmam_arm.sv @@
// ----------------------------------------------------------------------------
// Quad motor arming mixer arming machine
// Arming state, manual start flag and the four held motor levels.
// ----------------------------------------------------------------------------
module qmam_arm (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  qmam_pkg::in_word_t word,
  input  qmam_pkg::cfg_t     cfg,
  input  qmam_pkg::level_t   mix [4],
  output qmam_pkg::level_t   lvl_nxt [4],
  output logic               clr
);
  import qmam_pkg::*;

  arm_state_t state_r;
  arm_state_t state_nxt;
  arm_state_t s_in;
  logic       mp_r;
  logic       mp_nxt;
  logic       park;
  logic       go;
  logic       hold_idle;
  lvl_sel_t   sel;
  level_t     lvl_r [4];
  level_t     idle_s;

  assign idle_s    = $signed({3'b000, cfg.idle_level});
  assign go        = word.throttle > cfg.start_threshold;
  assign hold_idle = word.auto_mode && word.hold_request && word.armed &&
                     word.procedure_ready && (word.throttle < cfg.hold_threshold);

  // The flag overrides decide the state that acts in this tick.
  always_comb begin
    s_in = state_r;
    park = 1'b0;
    if (!word.armed) begin
      s_in = ST_EXIT;
    end
    if (word.unfolded && !word.armed && word.auto_mode) begin
      s_in = ST_PARKED;
      park = 1'b1;
    end
    if (word.unfolded && word.armed && word.auto_mode && word.procedure_ready) begin
      s_in = ST_WAIT_ARM;
    end
    if (!word.unfolded && word.armed && mp_r) begin
      s_in = ST_WAIT_ARM;
    end
  end

  always_comb begin
    state_nxt = s_in;
    mp_nxt    = mp_r;
    case (s_in)
      ST_WAIT_ARM, ST_WAIT_THR: begin
        if (s_in == ST_WAIT_ARM && word.armed) begin
          state_nxt = ST_WAIT_THR;
          mp_nxt    = 1'b0;
        end
        if (go) begin
          state_nxt = ST_RUN;
        end
        if (hold_idle) begin
          state_nxt = ST_WAIT_THR;
        end
      end
      ST_EXIT: state_nxt = ST_WAIT_ARM;
      default: begin
      end
    endcase
  end

  always_comb begin
    sel = LV_HOLD;
    clr = 1'b0;
    case (s_in)
      ST_WAIT_ARM, ST_WAIT_THR: begin
        if (hold_idle) begin
          sel = LV_IDLE;
        end else if (s_in == ST_WAIT_ARM) begin
          sel = LV_ZERO;
        end
      end
      ST_RUN: begin
        clr = 1'b1;
        sel = (word.throttle < cfg.cutoff_threshold) ? LV_ZERO : LV_MIX;
      end
      ST_EXIT: sel = LV_ZERO;
      default: sel = park ? LV_IDLE : LV_HOLD;
    endcase
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      case (sel)
        LV_ZERO: lvl_nxt[i] = '0;
        LV_IDLE: lvl_nxt[i] = idle_s;
        LV_MIX:  lvl_nxt[i] = mix[i];
        default: lvl_nxt[i] = lvl_r[i];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_WAIT_ARM;
      mp_r    <= 1'b1;
      for (int i = 0; i < 4; i++) begin
        lvl_r[i] <= '0;
      end
    end else if (step) begin
      state_r <= state_nxt;
      mp_r    <= mp_nxt;
      for (int i = 0; i < 4; i++) begin
        lvl_r[i] <= lvl_nxt[i];
      end
    end
  end

endmodule

@@ sv/quad_motor_arming_mixer.sv @@
// ----------------------------------------------------------------------------
// Quad motor arming mixer
// Arming state machine and X-frame motor mixer for one control tick a word.
// ----------------------------------------------------------------------------
// Each input word is one control tick and yields exactly one motor word. The
// block takes a new word in every cycle unless the motor channel stalls:
// a word sits in the input register, the arming state, held motor levels and
// clamped outputs are worked out from it combinationally, and the motor word
// is then loaded into the output register unless that register still holds a
// word not yet taken. The arming state and motor levels form a loop that sets
// the rate of one word per cycle. The user writes thresholds and limits over
// the APB port only while the block is idle; the block does not enforce this.
module quad_motor_arming_mixer (
  input  logic                         clk,
  input  logic                         rst_n,
  qmam_in_if.sink                      in_chan,
  qmam_out_if.source                   out_chan,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [qmam_pkg::ADDR_W-1:0]  paddr,
  input  logic [qmam_pkg::DATA_W-1:0]  pwdata,
  output logic [qmam_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);
  import qmam_pkg::*;

  cfg_t      cfg;
  in_word_t  in_r;
  in_word_t  in_nxt;
  logic      in_vld_r;
  logic      in_vld_nxt;
  out_word_t out_r;
  out_word_t out_nxt;
  logic      out_vld_r;
  logic      out_vld_nxt;
  logic      adv;
  logic      take;
  logic      step;
  logic      clr;
  level_t    mix [4];
  level_t    lvl_nxt [4];
  logic [MOT_W-1:0] mot [4];
  level_t    omax_s;

  qmam_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  qmam_mix u_mix (
    .word (in_r),
    .cfg  (cfg),
    .mix  (mix)
  );

  qmam_arm u_arm (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .word    (in_r),
    .cfg     (cfg),
    .mix     (mix),
    .lvl_nxt (lvl_nxt),
    .clr     (clr)
  );

  assign adv           = !out_vld_r || out_chan.ready;
  assign in_chan.ready = !in_vld_r || adv;
  assign take          = in_chan.valid && in_chan.ready;
  assign step          = in_vld_r && adv;

  assign in_nxt.armed           = in_chan.armed;
  assign in_nxt.unfolded        = in_chan.unfolded;
  assign in_nxt.auto_mode       = in_chan.auto_mode;
  assign in_nxt.hold_request    = in_chan.hold_request;
  assign in_nxt.procedure_ready = in_chan.procedure_ready;
  assign in_nxt.throttle        = in_chan.throttle;
  assign in_nxt.height_drive    = in_chan.height_drive;
  assign in_nxt.roll_drive      = in_chan.roll_drive;
  assign in_nxt.pitch_drive     = in_chan.pitch_drive;
  assign in_nxt.yaw_drive       = in_chan.yaw_drive;

  assign omax_s = $signed({3'b000, cfg.output_max});

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (lvl_nxt[i] < 0) begin
        mot[i] = '0;
      end else if (lvl_nxt[i] > omax_s) begin
        mot[i] = cfg.output_max;
      end else begin
        mot[i] = lvl_nxt[i][MOT_W-1:0];
      end
    end
  end

  assign out_nxt.motor_one        = mot[0];
  assign out_nxt.motor_two        = mot[1];
  assign out_nxt.motor_three      = mot[2];
  assign out_nxt.motor_four       = mot[3];
  assign out_nxt.clear_hold_flags = clr;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (take) begin
      in_vld_nxt = 1'b1;
    end else if (step) begin
      in_vld_nxt = 1'b0;
    end
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (step) begin
      out_vld_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_r <= in_nxt;
    end
    if (step) begin
      out_r <= out_nxt;
    end
  end

  assign out_chan.valid            = out_vld_r;
  assign out_chan.motor_one        = out_r.motor_one;
  assign out_chan.motor_two        = out_r.motor_two;
  assign out_chan.motor_three      = out_r.motor_three;
  assign out_chan.motor_four       = out_r.motor_four;
  assign out_chan.clear_hold_flags = out_r.clear_hold_flags;

endmodule

@@ verif/qmam_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Quad motor arming mixer checker
// Watches the tick and motor channels and the register port, keeps its own
// copy of the arming state, motor levels and settings, predicts each motor
// word and compares every accepted motor word field by field.
// ----------------------------------------------------------------------------
module qmam_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  qmam_in_if                           in_w,
  qmam_out_if                          out_w,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic                         pready,
  input  logic [qmam_pkg::ADDR_W-1:0]  paddr,
  input  logic [qmam_pkg::DATA_W-1:0]  pwdata,
  output int                           mismatch_count,
  output int                           pending_count
);
  import qmam_pkg::*;

  cfg_t               cfg;
  arm_state_t         arm_st;
  logic               manual_pend;
  logic signed [15:0] motor_lvl [4];
  out_word_t          expected_motor_words [$];
  out_word_t          exp_w;
  in_word_t           tick_w;

  function automatic int sat16(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic void set_levels(int v);
    for (int k = 0; k < 4; k++) motor_lvl[k] = 16'(v);
  endfunction

  function automatic logic [MOT_W-1:0] clamp_motor(int v);
    int c;
    c = v;
    if (c < 0) c = 0;
    if (c > int'(cfg.output_max)) c = int'(cfg.output_max);
    return c[MOT_W-1:0];
  endfunction

  function automatic out_word_t predict_motor_word(in_word_t w);
    out_word_t r;
    int        thr;
    int        base;
    int        hgt;
    int        rx;
    int        py;
    int        yz;
    r   = '0;
    thr = int'(w.throttle);
    hgt = int'($signed(w.height_drive));
    rx  = int'($signed(w.roll_drive));
    py  = int'($signed(w.pitch_drive));
    yz  = int'($signed(w.yaw_drive));

    if (!w.armed) arm_st = ST_EXIT;
    if (w.unfolded && !w.armed && w.auto_mode) begin
      arm_st = ST_PARKED;
      set_levels(int'(cfg.idle_level));
    end
    if (w.unfolded && w.armed && w.auto_mode && w.procedure_ready) arm_st = ST_WAIT_ARM;
    if (!w.unfolded && w.armed && manual_pend) arm_st = ST_WAIT_ARM;

    case (arm_st)
      ST_WAIT_ARM, ST_WAIT_THR: begin
        if (arm_st == ST_WAIT_ARM) begin
          set_levels(0);
          if (w.armed) begin
            arm_st      = ST_WAIT_THR;
            manual_pend = 1'b0;
          end
        end
        if (thr > int'(cfg.start_threshold)) arm_st = ST_RUN;
        if (w.auto_mode && w.hold_request && thr < int'(cfg.hold_threshold) &&
            w.armed && w.procedure_ready) begin
          set_levels(int'(cfg.idle_level));
          arm_st = ST_WAIT_THR;
        end
      end
      ST_RUN: begin
        r.clear_hold_flags = 1'b1;
        if (thr < int'(cfg.cutoff_threshold)) begin
          set_levels(0);
        end else begin
          base = sat16(thr - int'(cfg.throttle_offset) + hgt);
          if (base < 0) base = 0;
          if (base > int'(cfg.base_limit)) base = int'(cfg.base_limit);
          motor_lvl[0] = 16'(sat16(base + rx - py - yz));
          motor_lvl[1] = 16'(sat16(base + rx + py + yz));
          motor_lvl[2] = 16'(sat16(base - rx + py - yz));
          motor_lvl[3] = 16'(sat16(base - rx - py + yz));
        end
      end
      ST_EXIT: begin
        set_levels(0);
        arm_st = ST_WAIT_ARM;
      end
      default: begin
      end
    endcase

    r.motor_one   = clamp_motor(int'(motor_lvl[0]));
    r.motor_two   = clamp_motor(int'(motor_lvl[1]));
    r.motor_three = clamp_motor(int'(motor_lvl[2]));
    r.motor_four  = clamp_motor(int'(motor_lvl[3]));
    return r;
  endfunction

  task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
    end
  endtask

  initial begin
    mismatch_count = 0;
    pending_count  = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      cfg.throttle_offset  = THROTTLE_OFFSET_RST;
      cfg.start_threshold  = START_THRESHOLD_RST;
      cfg.hold_threshold   = HOLD_THRESHOLD_RST;
      cfg.cutoff_threshold = CUTOFF_THRESHOLD_RST;
      cfg.idle_level       = IDLE_LEVEL_RST;
      cfg.base_limit       = BASE_LIMIT_RST;
      cfg.output_max       = OUTPUT_MAX_RST;
      arm_st               = ST_WAIT_ARM;
      manual_pend          = 1'b1;
      set_levels(0);
      expected_motor_words.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[4:2]))
          REG_THROTTLE_OFFSET:  cfg.throttle_offset  = pwdata[THR_W-1:0];
          REG_START_THRESHOLD:  cfg.start_threshold  = pwdata[THR_W-1:0];
          REG_HOLD_THRESHOLD:   cfg.hold_threshold   = pwdata[THR_W-1:0];
          REG_CUTOFF_THRESHOLD: cfg.cutoff_threshold = pwdata[THR_W-1:0];
          REG_IDLE_LEVEL:       cfg.idle_level       = pwdata[MOT_W-1:0];
          REG_BASE_LIMIT:       cfg.base_limit       = pwdata[MOT_W-1:0];
          REG_OUTPUT_MAX:       cfg.output_max       = pwdata[MOT_W-1:0];
          default: begin
          end
        endcase
      end

      if (out_w.valid && out_w.ready) begin
        if (expected_motor_words.size() == 0) begin
          mismatch_count++;
          $display("%0t: motor word arrived with none expected, actual %0d %0d %0d %0d %0d",
                   $time, out_w.motor_one, out_w.motor_two, out_w.motor_three,
                   out_w.motor_four, out_w.clear_hold_flags);
        end else begin
          exp_w = expected_motor_words.pop_front();
          check_field("motor_one", exp_w.motor_one, out_w.motor_one);
          check_field("motor_two", exp_w.motor_two, out_w.motor_two);
          check_field("motor_three", exp_w.motor_three, out_w.motor_three);
          check_field("motor_four", exp_w.motor_four, out_w.motor_four);
          check_field("clear_hold_flags", exp_w.clear_hold_flags, out_w.clear_hold_flags);
        end
      end

      if (in_w.valid && in_w.ready) begin
        tick_w.armed           = in_w.armed;
        tick_w.unfolded        = in_w.unfolded;
        tick_w.auto_mode       = in_w.auto_mode;
        tick_w.hold_request    = in_w.hold_request;
        tick_w.procedure_ready = in_w.procedure_ready;
        tick_w.throttle        = in_w.throttle;
        tick_w.height_drive    = in_w.height_drive;
        tick_w.roll_drive      = in_w.roll_drive;
        tick_w.pitch_drive     = in_w.pitch_drive;
        tick_w.yaw_drive       = in_w.yaw_drive;
        expected_motor_words.push_back(predict_motor_word(tick_w));
      end
    end
    pending_count = expected_motor_words.size();
  end

endmodule

@@ verif/quad_motor_arming_mixer_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Quad motor arming mixer testbench
// Drives control tick words and register writes into the mixer, with random
// idle bursts on both channels and one long stall of the motor channel. A
// short directed sequence walks the arming states, then biased random ticks
// run under several register settings, the extremes among them.
// ----------------------------------------------------------------------------
module quad_motor_arming_mixer_tb;
  import qmam_pkg::*;

  localparam int PHASE_WORDS    = 300;
  localparam int NUM_PHASES     = 7;
  localparam int HOLD_OFF_TICKS = 48;
  localparam int WATCHDOG_LIMIT = 2000;

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  int   mismatch_count;
  int   pending_count;
  int   quiet_cycles;
  bit   idle_en;
  bit   hold_off_req;
  cfg_t cur_cfg;

  qmam_in_if  in_chan ();
  qmam_out_if out_chan ();

  quad_motor_arming_mixer uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  qmam_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_w           (in_chan),
    .out_w          (out_chan),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .pready         (pready),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n || psel || (in_chan.valid && in_chan.ready) ||
        (out_chan.valid && out_chan.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("quad_motor_arming_mixer_tb failed");
        $finish;
      end
    end
  end

  initial begin : motor_sink
    int n;
    out_chan.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_chan.ready <= 1'b0;
        repeat (HOLD_OFF_TICKS) @(negedge clk);
        hold_off_req = 1'b0;
        out_chan.ready <= 1'b1;
      end else if (idle_en && $urandom_range(0, 6) == 0) begin
        out_chan.ready <= 1'b0;
        n = $urandom_range(1, 4);
        repeat (n) @(negedge clk);
        out_chan.ready <= 1'b1;
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  function automatic in_word_t mk_tick(bit arm, bit unf, bit aut, bit hld, bit prc,
                                       int thr, int hgt, int rx, int py, int yz);
    in_word_t w;
    w.armed           = arm;
    w.unfolded        = unf;
    w.auto_mode       = aut;
    w.hold_request    = hld;
    w.procedure_ready = prc;
    w.throttle        = THR_W'(thr);
    w.height_drive    = DRV_W'(hgt);
    w.roll_drive      = DRV_W'(rx);
    w.pitch_drive     = DRV_W'(py);
    w.yaw_drive       = DRV_W'(yz);
    return w;
  endfunction

  function automatic int near_level(logic [THR_W-1:0] centre);
    int t;
    t = int'(centre) + int'($urandom_range(0, 6)) - 3;
    if (t < 0) t = 0;
    if (t > 2047) t = 2047;
    return t;
  endfunction

  function automatic int rand_drive();
    case ($urandom_range(0, 9))
      0:       return -1000;
      1:       return 1000;
      2:       return 0;
      default: return int'($urandom_range(0, 2000)) - 1000;
    endcase
  endfunction

  function automatic in_word_t gen_tick_word();
    int thr;
    case ($urandom_range(0, 5))
      0:       thr = int'($urandom_range(0, 2047));
      1:       thr = near_level(cur_cfg.start_threshold);
      2:       thr = near_level(cur_cfg.cutoff_threshold);
      3:       thr = near_level(cur_cfg.hold_threshold);
      default: thr = int'($urandom_range(1000, 2047));
    endcase
    return mk_tick($urandom_range(0, 15) != 0, $urandom_range(0, 1) == 1,
                   $urandom_range(0, 1) == 1, $urandom_range(0, 1) == 1,
                   $urandom_range(0, 3) == 0, thr, rand_drive(), rand_drive(),
                   rand_drive(), rand_drive());
  endfunction

  task automatic send_word(in_word_t w);
    int n;
    @(negedge clk);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      in_chan.valid <= 1'b0;
      n = $urandom_range(1, 4);
      repeat (n) @(negedge clk);
    end
    in_chan.armed           <= w.armed;
    in_chan.unfolded        <= w.unfolded;
    in_chan.auto_mode       <= w.auto_mode;
    in_chan.hold_request    <= w.hold_request;
    in_chan.procedure_ready <= w.procedure_ready;
    in_chan.throttle        <= w.throttle;
    in_chan.height_drive    <= w.height_drive;
    in_chan.roll_drive      <= w.roll_drive;
    in_chan.pitch_drive     <= w.pitch_drive;
    in_chan.yaw_drive       <= w.yaw_drive;
    in_chan.valid           <= 1'b1;
    do @(posedge clk); while (!in_chan.ready);
  endtask

  task automatic drain_words();
    @(negedge clk);
    in_chan.valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
  endtask

  task automatic cfg_write(reg_idx_t idx, logic [DATA_W-1:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apply_config(cfg_t c);
    cfg_write(REG_THROTTLE_OFFSET, DATA_W'(c.throttle_offset));
    cfg_write(REG_START_THRESHOLD, DATA_W'(c.start_threshold));
    cfg_write(REG_HOLD_THRESHOLD, DATA_W'(c.hold_threshold));
    cfg_write(REG_CUTOFF_THRESHOLD, DATA_W'(c.cutoff_threshold));
    cfg_write(REG_IDLE_LEVEL, DATA_W'(c.idle_level));
    cfg_write(REG_BASE_LIMIT, DATA_W'(c.base_limit));
    cfg_write(REG_OUTPUT_MAX, DATA_W'(c.output_max));
    cur_cfg = c;
  endtask

  function automatic cfg_t pick_setting(int ph);
    cfg_t c;
    c = '{THROTTLE_OFFSET_RST, START_THRESHOLD_RST, HOLD_THRESHOLD_RST,
          CUTOFF_THRESHOLD_RST, IDLE_LEVEL_RST, BASE_LIMIT_RST, OUTPUT_MAX_RST};
    case (ph)
      1: c = '0;
      2: c = '{11'd2047, 11'd2047, 11'd2047, 11'd2047, 10'd1000, 10'd1000, 10'd1000};
      3: c = '{11'd0, 11'd1100, 11'd2047, 11'd0, 10'd1000, 10'd1000, 10'd1000};
      4: begin
        c.throttle_offset  = THR_W'($urandom_range(900, 1100));
        c.start_threshold  = THR_W'($urandom_range(1000, 1300));
        c.hold_threshold   = THR_W'($urandom_range(1000, 1400));
        c.cutoff_threshold = THR_W'($urandom_range(950, 1150));
        c.idle_level       = MOT_W'($urandom_range(0, 1000));
        c.base_limit       = MOT_W'($urandom_range(0, 1000));
        c.output_max       = MOT_W'($urandom_range(0, 1000));
      end
      5: begin
        c.throttle_offset  = THR_W'($urandom_range(0, 2047));
        c.start_threshold  = THR_W'($urandom_range(0, 2047));
        c.hold_threshold   = THR_W'($urandom_range(0, 2047));
        c.cutoff_threshold = THR_W'($urandom_range(0, 2047));
        c.idle_level       = MOT_W'($urandom_range(0, 1000));
        c.base_limit       = MOT_W'($urandom_range(0, 1000));
        c.output_max       = MOT_W'($urandom_range(0, 1000));
      end
      default: begin
      end
    endcase
    return c;
  endfunction

  initial begin : stimulus
    cfg_t setting;
    rst_n                   <= 1'b0;
    in_chan.valid           <= 1'b0;
    in_chan.armed           <= 1'b0;
    in_chan.unfolded        <= 1'b0;
    in_chan.auto_mode       <= 1'b0;
    in_chan.hold_request    <= 1'b0;
    in_chan.procedure_ready <= 1'b0;
    in_chan.throttle        <= '0;
    in_chan.height_drive    <= '0;
    in_chan.roll_drive      <= '0;
    in_chan.pitch_drive     <= '0;
    in_chan.yaw_drive       <= '0;
    psel                    <= 1'b0;
    penable                 <= 1'b0;
    pwrite                  <= 1'b0;
    paddr                   <= '0;
    pwdata                  <= '0;
    idle_en      = 1'b1;
    hold_off_req = 1'b0;
    cur_cfg      = pick_setting(0);
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Walk the arming states under the reset settings.
    send_word(mk_tick(0, 0, 0, 0, 0, 1500, 0, 0, 0, 0));
    send_word(mk_tick(1, 0, 0, 0, 0, 1000, 0, 0, 0, 0));
    send_word(mk_tick(1, 0, 0, 0, 0, 1101, 0, 0, 0, 0));
    send_word(mk_tick(1, 0, 0, 0, 0, 2047, 1000, 1000, -1000, -1000));
    send_word(mk_tick(1, 0, 0, 0, 0, 1020, -1000, -1000, 1000, 1000));
    send_word(mk_tick(1, 0, 0, 0, 0, 1019, 500, 300, 200, 100));
    send_word(mk_tick(1, 0, 0, 0, 0, 0, -1000, -1000, -1000, -1000));
    send_word(mk_tick(1, 0, 0, 0, 0, 1500, 37, -200, 150, 90));
    send_word(mk_tick(0, 1, 1, 0, 0, 1500, 0, 0, 0, 0));
    send_word(mk_tick(1, 1, 1, 0, 0, 1500, 400, 400, 400, 400));
    send_word(mk_tick(1, 1, 1, 1, 1, 1150, 0, 0, 0, 0));
    send_word(mk_tick(1, 1, 1, 1, 1, 1199, 0, 0, 0, 0));
    send_word(mk_tick(1, 1, 1, 1, 1, 1200, 0, 0, 0, 0));
    send_word(mk_tick(1, 1, 1, 0, 0, 1600, 500, -300, 250, -125));
    send_word(mk_tick(0, 0, 1, 1, 1, 1600, 0, 0, 0, 0));
    send_word(mk_tick(1, 0, 1, 1, 1, 1300, 0, 0, 0, 0));
    send_word(mk_tick(1, 0, 0, 0, 0, 1100, 0, 0, 0, 0));
    send_word(mk_tick(1, 0, 1, 1, 1, 1100, 0, 0, 0, 0));
    send_word(mk_tick(1, 0, 0, 0, 0, 2047, 1000, 1000, 1000, 1000));
    send_word(mk_tick(1, 0, 0, 0, 0, 2047, 1000, 1000, 1000, 1000));
    send_word(mk_tick(1, 0, 0, 0, 0, 1800, -1000, -1000, -1000, -1000));

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain_words();
      setting = pick_setting(ph);
      apply_config(setting);
      if (ph == NUM_PHASES - 1) idle_en = 1'b0;
      for (int i = 0; i < PHASE_WORDS; i++) begin
        if (ph == 3 && i == 60) hold_off_req = 1'b1;
        send_word(gen_tick_word());
      end
    end

    drain_words();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("quad_motor_arming_mixer_tb passed");
    end else begin
      $display("quad_motor_arming_mixer_tb failed");
    end
    $finish;
  end

endmodule
